// ===== design/srr_pkg.sv =====
// Package for the selective-repeat receiver: sizes, register map,
// reset values and the sequencer state type.
// No dependencies; every other file in this folder imports it.
package srr_pkg;

  localparam int DEF_WINDOW_SLOTS = 4;
  localparam int DEF_SEQ_BITS     = 8;
  localparam int DEF_PAYLOAD_BITS = 64;

  // Fixed field widths.
  localparam int SEQ_NUM_W  = 8;
  localparam int MODULUS_W  = 9;
  localparam int WINLEN_W   = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_SEQ_MODULUS = 1'b0;
  localparam logic REG_WINDOW_LEN  = 1'b1;

  localparam logic [MODULUS_W-1:0] SEQ_MODULUS_RST = MODULUS_W'(8);
  localparam logic [WINLEN_W-1:0]  WINDOW_LEN_RST  = WINLEN_W'(4);

  // Result kinds.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SEQ,
    ST_DIV_BASE,
    ST_OFFSET,
    ST_CHECK,
    ST_DELIVER,
    ST_ACK
  } state_t;

endpackage

// ===== design/srr_pkt_if.sv =====
// Packet channel of the selective-repeat receiver: valid/ready handshake
// with checksum flag, sequence number and payload. Depends on srr_pkg.
interface srr_pkt_if import srr_pkg::*; #(
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic                    checksum_ok;
  logic [SEQ_NUM_W-1:0]    seq_num;
  logic [PAYLOAD_BITS-1:0] payload_word;

  modport source (output valid, checksum_ok, seq_num, payload_word, input ready);
  modport sink   (input valid, checksum_ok, seq_num, payload_word, output ready);
endinterface

// ===== design/srr_res_if.sv =====
// Result channel of the selective-repeat receiver: in-order deliveries
// and acknowledgements under a valid/ready handshake. Depends on srr_pkg.
interface srr_res_if import srr_pkg::*; #(
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [PAYLOAD_BITS-1:0] deliver_data;
  logic [SEQ_NUM_W-1:0]    ack_number;
  logic                    last;

  modport source (output valid, kind, deliver_data, ack_number, last, input ready);
  modport sink   (input valid, kind, deliver_data, ack_number, last, output ready);
endinterface

// ===== design/selective_repeat_receiver.sv =====
// Selective-repeat ARQ receiver top level: APB register port, sequencer,
// shared remainder unit, slot buffer and result register.
// Depends on srr_pkg, srr_pkt_if and srr_res_if.
//
// Usage: packets arrive on pkt and are taken one at a time; pkt.ready is high
// only while the sequencer is idle. A packet with checksum_ok low is taken
// and produces nothing. A good packet runs through one shared restoring
// remainder unit, one bit per cycle: first the sequence number, then the
// window base, each reduced by the sequence modulus as a DW = max(8, SEQ_BITS)
// bit dividend. The offset step then forms the window offset, and the check
// step fills the slot if the packet falls in the window. A buffered packet
// then passes to the delivery step, which hands out every in-order item and
// leaves once the base slot is empty; the acknowledgement (last = 1) follows.
// Results leave through a single output register; the next packet is taken
// while the acknowledgement still waits there. When that register is full
// and res.ready is low, the sequencer holds in its delivery or acknowledgement
// step until the register is free. Reset empties all slots, zeroes the window
// base, sets the modulus to 8 and the window length to 4. Registers are to be
// written over APB only while the block is idle; the block does not enforce it.
module selective_repeat_receiver import srr_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int SEQ_BITS     = DEF_SEQ_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  srr_pkt_if.sink               pkt,
  srr_res_if.source             res
);

  localparam int DW     = (SEQ_BITS > SEQ_NUM_W) ? SEQ_BITS : SEQ_NUM_W;
  localparam int CNT_W  = $clog2(DW + 1);
  localparam int MW     = SEQ_BITS + 1;
  localparam int EW     = (MW > MODULUS_W) ? MW : MODULUS_W;
  localparam int WS_W   = $clog2(WINDOW_SLOTS + 1);
  localparam int WW     = (WS_W > WINLEN_W) ? WS_W : WINLEN_W;
  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CW0    = (MW > WW) ? MW : WW;
  localparam int CMP_W  = (CW0 > SLOT_W) ? CW0 : SLOT_W;

  // Configuration registers.
  logic [MODULUS_W-1:0] seq_modulus;
  logic [WINLEN_W-1:0]  window_len;

  // Sequencer and datapath state.
  state_t                  state, state_next;
  logic [CNT_W-1:0]        cnt;
  logic [DW-1:0]           dvd;
  logic [SEQ_BITS-1:0]     rem;
  logic [SEQ_BITS-1:0]     rs;
  logic [SEQ_BITS-1:0]     rb;
  logic [SEQ_BITS-1:0]     base;
  logic [MW-1:0]           off;
  logic [SEQ_NUM_W-1:0]    seq;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [WINDOW_SLOTS-1:0] filled;
  logic [PAYLOAD_BITS-1:0] slot [WINDOW_SLOTS];

  // Output register.
  logic                    ov;
  logic                    o_kind;
  logic [PAYLOAD_BITS-1:0] o_data;
  logic [SEQ_NUM_W-1:0]    o_ack;
  logic                    o_last;

  // Combinational signals.
  logic                    cfg_wr;
  logic [EW-1:0]           mod_ext;
  logic [MW-1:0]           modv;
  logic [WW-1:0]           win;
  logic [MW-1:0]           tmp;
  logic [MW-1:0]           tmp_sub;
  logic [SEQ_BITS-1:0]     rem_step;
  logic [MW-1:0]           diff;
  logic [MW-1:0]           inc;
  logic [SEQ_BITS-1:0]     nb;
  logic [CMP_W-1:0]        off_cmp;
  logic [SLOT_W-1:0]       idx;
  logic                    hit;
  logic                    div_last;
  logic                    out_free;
  logic                    take_pkt;
  logic                    load_deliver;
  logic                    load_ack;

  // ---------------- APB register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_modulus <= SEQ_MODULUS_RST;
      window_len  <= WINDOW_LEN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SEQ_MODULUS: seq_modulus <= pwdata[MODULUS_W-1:0];
        REG_WINDOW_LEN:  window_len  <= pwdata[WINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SEQ_MODULUS: prdata = APB_DATA_W'(seq_modulus);
      REG_WINDOW_LEN:  prdata = APB_DATA_W'(window_len);
      default:         prdata = '0;
    endcase
  end

  // ---------------- Effective modulus and window ----------------
  always_comb begin
    mod_ext = EW'(seq_modulus);
    if (mod_ext < EW'(2)) begin
      mod_ext = EW'(2);
    end else if (mod_ext > (EW'(1) << SEQ_BITS)) begin
      mod_ext = EW'(1) << SEQ_BITS;
    end
    modv = mod_ext[MW-1:0];
  end

  assign win = (WW'(window_len) > WW'(WINDOW_SLOTS)) ? WW'(WINDOW_SLOTS) : WW'(window_len);

  // ---------------- Shared remainder unit ----------------
  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign tmp      = {rem, dvd[DW-1]};
  assign tmp_sub  = tmp - modv;
  assign rem_step = (tmp >= modv) ? tmp_sub[SEQ_BITS-1:0] : tmp[SEQ_BITS-1:0];
  assign div_last = (cnt == CNT_W'(1));

  // Both operands are already reduced, so the offset needs one correction.
  assign diff = {1'b0, rs} + modv - {1'b0, rb};

  // Base advance from the reduced base.
  assign inc = {1'b0, rb} + MW'(1);
  assign nb  = (inc == modv) ? '0 : inc[SEQ_BITS-1:0];

  assign off_cmp = CMP_W'(off);
  assign idx     = off_cmp[SLOT_W-1:0];
  assign hit     = (off_cmp < CMP_W'(win)) && !filled[idx];

  assign out_free = !ov || res.ready;

  // ---------------- Sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    take_pkt     = 1'b0;
    load_deliver = 1'b0;
    load_ack     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        take_pkt = pkt.valid;
        if (pkt.valid && pkt.checksum_ok) begin
          state_next = ST_DIV_SEQ;
        end
      end
      ST_DIV_SEQ: begin
        if (div_last) begin
          state_next = ST_DIV_BASE;
        end
      end
      ST_DIV_BASE: begin
        if (div_last) begin
          state_next = ST_OFFSET;
        end
      end
      ST_OFFSET: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = hit ? ST_DELIVER : ST_ACK;
      end
      ST_DELIVER: begin
        if (!filled[0]) begin
          state_next = ST_ACK;
        end else if (out_free) begin
          load_deliver = 1'b1;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          load_ack   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign pkt.ready = (state == ST_IDLE);

  // ---------------- Datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (take_pkt) begin
      cnt <= CNT_W'(DW);
    end else if (state == ST_DIV_SEQ || state == ST_DIV_BASE) begin
      cnt <= div_last ? CNT_W'(DW) : cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take_pkt) begin
      seq     <= pkt.seq_num;
      payload <= pkt.payload_word;
      dvd     <= DW'(pkt.seq_num);
      rem     <= '0;
    end else if (state == ST_DIV_SEQ) begin
      if (div_last) begin
        rs  <= rem_step;
        dvd <= DW'(base);
        rem <= '0;
      end else begin
        rem <= rem_step;
        dvd <= dvd << 1;
      end
    end else if (state == ST_DIV_BASE) begin
      rem <= rem_step;
      dvd <= dvd << 1;
      if (div_last) begin
        rb <= rem_step;
      end
    end else if (state == ST_OFFSET) begin
      off <= (diff >= modv) ? diff - modv : diff;
    end else if (load_deliver) begin
      rb <= nb;
    end
  end

  // Window base: stored reduced on every advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (load_deliver) begin
      base <= nb;
    end
  end

  // Slot buffer: slot 0 is the base; a delivery shifts everything down one.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (state == ST_CHECK && hit) begin
      filled[idx] <= 1'b1;
    end else if (load_deliver) begin
      for (int i = 0; i < WINDOW_SLOTS - 1; i++) begin
        filled[i] <= filled[i+1];
      end
      filled[WINDOW_SLOTS-1] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK && hit) begin
      slot[idx] <= payload;
    end else if (load_deliver) begin
      for (int i = 0; i < WINDOW_SLOTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  // ---------------- Output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load_deliver || load_ack) begin
      ov <= 1'b1;
    end else if (res.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_deliver) begin
      o_kind <= KIND_DELIVER;
      o_data <= slot[0];
      o_ack  <= '0;
      o_last <= 1'b0;
    end else if (load_ack) begin
      o_kind <= KIND_ACK;
      o_data <= '0;
      o_ack  <= seq;
      o_last <= 1'b1;
    end
  end

  assign res.valid        = ov;
  assign res.kind         = o_kind;
  assign res.deliver_data = o_data;
  assign res.ack_number   = o_ack;
  assign res.last         = o_last;

  // ---------------- Assertions ----------------
  // Deliveries drain the base slot before the block goes idle again.
  a_idle_base_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !filled[0])
    else $error("base slot filled while idle");

  // The reduced base used for advancing stays inside the sequence space.
  a_rb_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DELIVER |-> ({1'b0, rb} < modv))
    else $error("reduced base not below modulus");

  // Only the acknowledgement closes a packet's results.
  a_last_is_ack: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.last == (res.kind == KIND_ACK)))
    else $error("last flag disagrees with result kind");

  // A delivery advances the base by one step.
  a_base_advance: assert property (@(posedge clk) disable iff (rst)
    load_deliver |=> base == $past(nb))
    else $error("window base did not advance on delivery");

endmodule
